FILE: src/cle_pkg.sv
package cle_pkg;

	// buffer geometry
	localparam int CAPACITY = 256;
	localparam int LEN_W    = $clog2(CAPACITY);
	localparam int GRP_SZ   = 16;
	localparam int NGRP     = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

	// printable ascii range for insert
	localparam logic [7:0] CHAR_LO = 8'd32;
	localparam logic [7:0] CHAR_HI = 8'd126;

	// edit opcodes
	localparam logic [3:0] OP_CLEAR  = 4'd0;
	localparam logic [3:0] OP_LOAD   = 4'd1;
	localparam logic [3:0] OP_INSERT = 4'd2;
	localparam logic [3:0] OP_BKSP   = 4'd3;
	localparam logic [3:0] OP_DEL    = 4'd4;
	localparam logic [3:0] OP_LEFT   = 4'd5;
	localparam logic [3:0] OP_RIGHT  = 4'd6;
	localparam logic [3:0] OP_HOME   = 4'd7;
	localparam logic [3:0] OP_END    = 4'd8;
	localparam logic [3:0] OP_READ   = 4'd9;

	// per-cell update modes
	localparam logic [1:0] CELL_HOLD  = 2'd0;
	localparam logic [1:0] CELL_WRITE = 2'd1;
	localparam logic [1:0] CELL_SHR   = 2'd2;
	localparam logic [1:0] CELL_SHL   = 2'd3;

	// command broadcast to every cell
	typedef struct packed {
		logic [1:0]       mode;
		logic [LEN_W-1:0] point;
		logic [7:0]       ch;
	} cell_cmd_t;

	// outcome of one request
	typedef struct packed {
		logic             accepted;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] cur;
	} edit_res_t;

	// low byte of a length or cursor value
	function automatic logic [7:0] to_byte(input logic [LEN_W-1:0] v);
		logic [LEN_W+7:0] w;
		w = {8'd0, v};
		return w[7:0];
	endfunction

	// byte position widened or narrowed to index width
	function automatic logic [LEN_W-1:0] to_idx(input logic [7:0] b);
		logic [LEN_W+7:0] w;
		w = {{LEN_W{1'b0}}, b};
		return w[LEN_W-1:0];
	endfunction

	// byte position below a length
	function automatic logic pos_below(input logic [7:0] b, input logic [LEN_W-1:0] v);
		logic [LEN_W+7:0] wb;
		logic [LEN_W+7:0] wv;
		wb = {{LEN_W{1'b0}}, b};
		wv = {8'd0, v};
		return wb < wv;
	endfunction

endpackage

FILE: src/cle_cell.sv
module cle_cell (
	input  logic                    clk,
	input  cle_pkg::cell_cmd_t      cmd,
	input  logic [cle_pkg::LEN_W-1:0] idx,
	input  logic [7:0]              left,
	input  logic [7:0]              right,
	output logic [7:0]              data
);
	import cle_pkg::*;

	logic [7:0] data_q;
	logic [7:0] data_d;

	// pick own, neighbor or new character
	always_comb begin
		data_d = data_q;
		case (cmd.mode)
			CELL_WRITE: begin
				if (idx == cmd.point) data_d = cmd.ch;
			end
			CELL_SHR: begin
				if (idx > cmd.point) data_d = left;
				else if (idx == cmd.point) data_d = cmd.ch;
			end
			CELL_SHL: begin
				if (idx >= cmd.point) data_d = right;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

FILE: src/cle_ctrl.sv
module cle_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [3:0]         opcode,
	input  logic [7:0]         char_in,
	input  logic [7:0]         read_position,
	output cle_pkg::cell_cmd_t cmd,
	output cle_pkg::edit_res_t res
);
	import cle_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cur_q;
	logic             full;
	edit_res_t        nxt;
	cell_cmd_t        cmd_d;

	assign full = (len_q == LEN_W'(CAPACITY - 1));

	// decode the edit and the new length and cursor
	always_comb begin
		nxt.accepted = 1'b0;
		nxt.len      = len_q;
		nxt.cur      = cur_q;
		cmd_d.mode   = CELL_HOLD;
		cmd_d.point  = cur_q;
		cmd_d.ch     = char_in;
		case (opcode)
			OP_CLEAR: begin
				nxt.len      = '0;
				nxt.cur      = '0;
				nxt.accepted = 1'b1;
			end
			OP_LOAD: begin
				if (char_in != 8'd0 && !full) begin
					cmd_d.mode   = CELL_WRITE;
					cmd_d.point  = len_q;
					nxt.len      = len_q + 1'b1;
					nxt.cur      = len_q + 1'b1;
					nxt.accepted = 1'b1;
				end
			end
			OP_INSERT: begin
				if (char_in inside {[CHAR_LO:CHAR_HI]} && !full) begin
					cmd_d.mode   = CELL_SHR;
					nxt.len      = len_q + 1'b1;
					nxt.cur      = cur_q + 1'b1;
					nxt.accepted = 1'b1;
				end
			end
			OP_BKSP: begin
				if (cur_q != '0) begin
					cmd_d.mode   = CELL_SHL;
					cmd_d.point  = cur_q - 1'b1;
					nxt.len      = len_q - 1'b1;
					nxt.cur      = cur_q - 1'b1;
					nxt.accepted = 1'b1;
				end
			end
			OP_DEL: begin
				if (cur_q < len_q) begin
					cmd_d.mode   = CELL_SHL;
					nxt.len      = len_q - 1'b1;
					nxt.accepted = 1'b1;
				end
			end
			OP_LEFT: begin
				if (cur_q != '0) begin
					nxt.cur      = cur_q - 1'b1;
					nxt.accepted = 1'b1;
				end
			end
			OP_RIGHT: begin
				if (cur_q < len_q) begin
					nxt.cur      = cur_q + 1'b1;
					nxt.accepted = 1'b1;
				end
			end
			OP_HOME: begin
				if (cur_q != '0) begin
					nxt.cur      = '0;
					nxt.accepted = 1'b1;
				end
			end
			OP_END: begin
				if (cur_q < len_q) begin
					nxt.cur      = len_q;
					nxt.accepted = 1'b1;
				end
			end
			OP_READ: begin
				nxt.accepted = pos_below(read_position, len_q);
			end
			default: nxt.accepted = 1'b0;
		endcase
	end

	// cells only move on an accepted request
	always_comb begin
		cmd = cmd_d;
		if (!fire) cmd.mode = CELL_HOLD;
	end

	assign res = nxt;

	// length and cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cur_q <= '0;
		end else if (fire) begin
			len_q <= nxt.len;
			cur_q <= nxt.cur;
		end
	end

`ifndef SYNTHESIS
	a_cur_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q)
		else $error("cursor beyond length");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && opcode == OP_CLEAR |=> len_q == '0 && cur_q == '0)
		else $error("clear left text behind");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(len_q) && $stable(cur_q))
		else $error("state moved without a request");

	a_len_capped: assert property (@(posedge clk) disable iff (!arst_n)
		fire && full && (opcode == OP_LOAD || opcode == OP_INSERT) |=> $stable(len_q))
		else $error("length grew past the cap");
`endif

endmodule

FILE: src/cursor_line_edit_buffer.sv
// Single-line edit buffer with a cursor, held in a row of character cells.
// Request channel (req_valid/req_ready): opcode, char_in, read_position.
// Response channel (rsp_valid/rsp_ready): accepted, text_length,
// cursor_position, read_char; exactly one response per request, in order.
// A request is taken in the idle state; the cells shift and the length and
// cursor update at that edge. The next cycle gathers the read byte through
// a registered OR tree over groups of cells; then, in the done state, the
// response is loaded into the output register once that register is free.
// A new request is taken only once the previous one has left the done
// state. The response register frees the request side: a new request is
// taken while the previous response still waits.
// When the receiver stalls with a response waiting, the finished result
// of the next request holds until the register drains, and no further
// request is taken meanwhile.
// Reset empties the buffer (length and cursor zero); cell contents are not
// cleared, as only cells below the length are ever read.
module cursor_line_edit_buffer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [3:0] opcode,
	input  logic [7:0] char_in,
	input  logic [7:0] read_position,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic       accepted,
	output logic [7:0] text_length,
	output logic [7:0] cursor_position,
	output logic [7:0] read_char
);
	import cle_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_GATHER = 2'd1;
	localparam logic [1:0] S_DONE   = 2'd2;

	logic [1:0]       st_q;
	logic             fire;
	logic             load_out;
	cell_cmd_t        cmd;
	edit_res_t        res;
	edit_res_t        res_q;
	logic             is_read_q;
	logic [LEN_W-1:0] pos_q;
	logic [7:0]       cell_data [CAPACITY];
	logic [7:0]       grp_d [NGRP];
	logic [7:0]       grp_q [NGRP];
	logic [7:0]       rd_byte;
	logic             rsp_valid_q;
	logic             accepted_q;
	logic [7:0]       text_length_q;
	logic [7:0]       cursor_position_q;
	logic [7:0]       read_char_q;

	assign req_ready = (st_q == S_IDLE);
	assign fire      = req_valid && req_ready;
	assign load_out  = (st_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	// length, cursor and edit decode
	cle_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.opcode        (opcode),
		.char_in       (char_in),
		.read_position (read_position),
		.cmd           (cmd),
		.res           (res)
	);

	// row of character cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [7:0] left_w;
		logic [7:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = 8'd0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = 8'd0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		cle_cell u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.idx   (LEN_W'(i)),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i])
		);
	end

	// first tree level: one OR per group of cells
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		always_comb begin
			grp_d[g] = 8'd0;
			for (int k = 0; k < GRP_SZ; k++) begin
				if (g * GRP_SZ + k < CAPACITY) begin
					if (pos_q == LEN_W'(g * GRP_SZ + k))
						grp_d[g] = grp_d[g] | cell_data[g * GRP_SZ + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_GATHER) grp_q <= grp_d;
	end

	// second tree level
	always_comb begin
		rd_byte = 8'd0;
		for (int g = 0; g < NGRP; g++) rd_byte = rd_byte | grp_q[g];
	end

	// request capture
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q     <= res;
			is_read_q <= (opcode == OP_READ);
			pos_q     <= to_idx(read_position);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			case (st_q)
				S_IDLE:   if (fire) st_q <= S_GATHER;
				S_GATHER: st_q <= S_DONE;
				S_DONE:   if (load_out) st_q <= S_IDLE;
				default:  st_q <= S_IDLE;
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			accepted_q        <= res_q.accepted;
			text_length_q     <= to_byte(res_q.len);
			cursor_position_q <= to_byte(res_q.cur);
			read_char_q       <= (is_read_q && res_q.accepted) ? rd_byte : 8'd0;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign accepted        = accepted_q;
	assign text_length     = text_length_q;
	assign cursor_position = cursor_position_q;
	assign read_char       = read_char_q;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> st_q == S_GATHER ##1 st_q == S_DONE)
		else $error("request sequence broken");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_char) && $stable(text_length))
		else $error("stalled response changed");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && !(is_read_q && res_q.accepted) |=> read_char == 8'd0)
		else $error("read byte on a non-read response");
`endif

endmodule
